>>> src/chm_pkg.sv
// Shared types and constants of the chained hash map.
package chm_pkg;

	localparam int BUCKETS = 64;
	localparam int ENTRIES = 256;
	localparam int BW = $clog2(BUCKETS);
	localparam int EW = $clog2(ENTRIES);
	localparam int LW = EW + 1;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CFG_W = 7;

	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_DELETE = 2'd2;
	localparam logic [1:0] FN_CLEAR  = 2'd3;

	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	typedef struct packed {
		logic [1:0]       func;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [BW-1:0]    bucket;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic             status;
	} res_t;

endpackage

>>> src/chm_front.sv
// Front end: takes items, works out the bucket and queues commands.
module chm_front import chm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	input  logic [CFG_W-1:0] bucket_count,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd
);

	// key modulo n by restoring division, one quotient bit a cycle
	localparam int DIV_STEPS = KEY_W;

	logic              busy_q;
	logic [4:0]        step_q;
	logic [KEY_W-1:0]  num_q;
	logic [BW:0]       rem_q;
	logic [BW:0]       div_q;
	logic [1:0]        func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [BW+1:0]     trial;
	logic [BW:0]       n_eff;
	logic              done;

	cmd_t              fifo_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;

	always_comb begin
		if (bucket_count == '0) n_eff = (BW+1)'(1);
		else if (bucket_count > CFG_W'(BUCKETS)) n_eff = (BW+1)'(BUCKETS);
		else n_eff = (BW+1)'(bucket_count);
	end

	assign trial = {rem_q, num_q[KEY_W-1]} - {1'b0, div_q};
	assign done = busy_q && step_q == 5'(DIV_STEPS) && cnt_q != 2'd2;
	assign in_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && step_q != 5'(DIV_STEPS)) begin
			step_q <= step_q + 5'd1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			num_q  <= key;
			rem_q  <= '0;
			div_q  <= n_eff;
			func_q <= func;
			key_q  <= key;
			val_q  <= value;
		end else if (busy_q && step_q != 5'(DIV_STEPS)) begin
			num_q <= {num_q[KEY_W-2:0], 1'b0};
			if (!trial[BW+1]) rem_q <= trial[BW:0];
			else rem_q <= {rem_q[BW-1:0], num_q[KEY_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (done) wp_q <= !wp_q;
			if (cmd_valid && cmd_ready) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(done) - 2'(cmd_valid && cmd_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			fifo_q[wp_q] <= '{func: func_q, key: key_q, value: val_q,
				bucket: rem_q[BW-1:0]};
		end
	end

	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = fifo_q[rp_q];

endmodule

>>> src/chm_back.sv
// Back end: walks bucket chains in the entry memories and updates them.
module chm_back import chm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	input  cmd_t  cmd,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_HEAD  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_CMP   = 4'd3;
	localparam logic [3:0] ST_POP   = 4'd4;
	localparam logic [3:0] ST_INS   = 4'd5;
	localparam logic [3:0] ST_CLR   = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;
	localparam logic [3:0] ST_INIT  = 4'd8;

	logic [3:0]       st_q;
	cmd_t             c_q;
	logic [LW-1:0]    cur_q, prev_q;
	logic [LW:0]      steps_q;
	logic [LW-1:0]    fcnt_q;
	logic [EW:0]      sweep_q;
	logic [BUCKETS-1:0] hvalid_q;
	logic [LW-1:0]    heads [BUCKETS];
	logic [LW-1:0]    rhead_q;

	logic [KEY_W-1:0] keys [ENTRIES];
	logic [VAL_W-1:0] vals [ENTRIES];
	logic [LW-1:0]    links [ENTRIES];
	logic [EW-1:0]    fstack [ENTRIES];
	logic [KEY_W-1:0] rkey_q;
	logic [VAL_W-1:0] rval_q;
	logic [LW-1:0]    rlink_q;
	logic [EW-1:0]    rfree_q;
	logic [LW-1:0]    head_rd;

	res_t             acc_q;
	res_t             res_q;
	logic             rv_q;

	assign head_rd = hvalid_q[c_q.bucket] ? rhead_q : NIL;
	assign cmd_ready = st_q == ST_IDLE;
	assign res_valid = rv_q;
	assign res = res_q;

	// entry memory reads, registered
	always_ff @(posedge clk) begin
		rkey_q  <= keys[cur_q[EW-1:0]];
		rval_q  <= vals[cur_q[EW-1:0]];
		rlink_q <= links[cur_q[EW-1:0]];
		rfree_q <= fstack[fcnt_q[EW-1:0] - EW'(1)];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_INIT || st_q == ST_CLR)
			fstack[sweep_q[EW-1:0]] <= EW'(ENTRIES - 1) - sweep_q[EW-1:0];
		else if (st_q == ST_CMP && c_q.func == FN_DELETE && rkey_q == c_q.key
				&& cur_q != NIL && fcnt_q < LW'(ENTRIES))
			fstack[fcnt_q[EW-1:0]] <= cur_q[EW-1:0];
		if (st_q == ST_INS) begin
			keys[rfree_q]  <= c_q.key;
			vals[rfree_q]  <= c_q.value;
			links[rfree_q] <= head_rd;
		end else if (st_q == ST_CMP && c_q.func == FN_DELETE && rkey_q == c_q.key
				&& prev_q != NIL)
			links[prev_q[EW-1:0]] <= rlink_q;
	end

	// bucket head read on command accept, held for the whole command
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			c_q     <= cmd;
			rhead_q <= heads[cmd.bucket];
		end
		if (st_q == ST_INS) heads[c_q.bucket] <= {1'b0, rfree_q};
		else if (st_q == ST_CMP && c_q.func == FN_DELETE && rkey_q == c_q.key
				&& prev_q == NIL)
			heads[c_q.bucket] <= rlink_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_INIT;
			sweep_q  <= '0;
			fcnt_q   <= LW'(ENTRIES);
			hvalid_q <= '0;
			rv_q     <= 1'b0;
			cur_q    <= '0;
			prev_q   <= NIL;
			steps_q  <= '0;
			acc_q    <= '0;
			res_q    <= '0;
		end else begin
			if (st_q == ST_OUT && (!rv_q || res_ready)) rv_q <= 1'b1;
			else if (rv_q && res_ready) rv_q <= 1'b0;
			unique case (st_q)
				ST_INIT, ST_CLR: begin
					if (sweep_q == (EW+1)'(ENTRIES - 1)) begin
						sweep_q <= '0;
						fcnt_q  <= LW'(ENTRIES);
						st_q    <= st_q == ST_CLR ? ST_OUT : ST_IDLE;
						acc_q   <= '0;
					end else sweep_q <= sweep_q + (EW+1)'(1);
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.func)
							FN_INSERT: st_q <= ST_POP;
							FN_CLEAR: begin
								hvalid_q <= '0;
								st_q     <= ST_CLR;
							end
							default: st_q <= ST_HEAD;
						endcase
					end
				end
				ST_POP: begin
					if (fcnt_q == '0) begin
						acc_q <= '{found: 1'b0, read_value: '0, status: 1'b1};
						st_q  <= ST_OUT;
					end else st_q <= ST_INS;
				end
				ST_INS: begin
					hvalid_q[c_q.bucket] <= 1'b1;
					fcnt_q <= fcnt_q - LW'(1);
					acc_q  <= '0;
					st_q   <= ST_OUT;
				end
				ST_HEAD: begin
					cur_q   <= head_rd;
					prev_q  <= NIL;
					steps_q <= '0;
					st_q    <= ST_RD;
				end
				ST_RD: begin
					if (cur_q == NIL || steps_q >= (LW+1)'(ENTRIES)) begin
						cur_q <= NIL;
						acc_q <= '0;
						st_q  <= ST_OUT;
					end else st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rkey_q == c_q.key) begin
						acc_q.found      <= 1'b1;
						acc_q.read_value <= c_q.func == FN_LOOKUP ? rval_q : '0;
						acc_q.status     <= 1'b0;
						if (c_q.func == FN_DELETE) begin
							hvalid_q[c_q.bucket] <= 1'b1;
							if (fcnt_q < LW'(ENTRIES)) fcnt_q <= fcnt_q + LW'(1);
						end
						st_q <= ST_OUT;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rlink_q;
						steps_q <= steps_q + (LW+1)'(1);
						st_q    <= ST_RD;
					end
				end
				ST_OUT: begin
					// hold while the previous result still waits
					if (!rv_q || res_ready) begin
						res_q <= acc_q;
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/chained_hash_map.sv
// Top level of the chained hash map: front end, command queue and back end.
//  channel   dir  fields
//  s_axis    in   tdata: func, key, value
//  m_axis    out  tdata: found, read_value, status
//  cfg       in   bucket_count
// The front end works out the key modulo bucket count before taking the next item,
// holding while the two-deep command queue is full. The back end pops the free stack
// and links the new entry at the bucket head for insert, and walks the chain comparing
// entries for lookup and delete; clear sweeps the free stack. After reset a free stack
// sweep runs before the first item is carried out. A waiting result holds the back end.
module chained_hash_map import chm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // func[1:0], key[32:2], value[64:33]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // found[0], read_value[32:1], status[33]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	logic [CFG_W-1:0] bc_q;
	logic             cmd_valid, cmd_ready;
	cmd_t             cmd;
	res_t             res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bc_q <= CFG_W'(64);
		else if (cfg_valid) bc_q <= cfg_data;
	end

	chm_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.func(s_axis_tdata[1:0]), .key(s_axis_tdata[32:2]),
		.value(s_axis_tdata[64:33]), .bucket_count(bc_q),
		.cmd_valid, .cmd_ready, .cmd
	);

	chm_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {6'd0, res.status, res.read_value, res.found};

endmodule

>>> tb/chained_hash_map_test.sv
// Self-checking testbench of the chained hash map against a local map model.
module chained_hash_map_test;
	import chm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;   // func[1:0], key[32:2], value[64:33]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // found[0], read_value[32:1], status[33]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	chained_hash_map uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	typedef struct {
		logic [1:0]       func;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} op_t;

	// map model
	logic [CFG_W-1:0] map_buckets;
	logic [LW-1:0]    map_heads [BUCKETS];
	logic [KEY_W-1:0] map_keys [ENTRIES];
	logic [VAL_W-1:0] map_vals [ENTRIES];
	logic [LW-1:0]    map_links [ENTRIES];
	logic [EW-1:0]    map_free [ENTRIES];
	int               map_free_n;

	op_t  pending_ops[$];
	res_t expected_res[$];
	int   errors;
	int   send_idle, recv_idle;
	int   n_sent, n_checked;
	logic [KEY_W-1:0] live_keys[$];
	logic s_axis_tready_q;
	op_t  took;

	function automatic void map_clear();
		for (int i = 0; i < BUCKETS; i++) map_heads[i] = NIL;
		for (int i = 0; i < ENTRIES; i++) map_free[i] = EW'(ENTRIES - 1 - i);
		map_free_n = ENTRIES;
	endfunction

	function automatic res_t map_apply(op_t op);
		res_t r;
		int n, b, cur, prev, steps, e;
		r = '0;
		n = map_buckets;
		if (n == 0) n = 1;
		if (n > BUCKETS) n = BUCKETS;
		b = op.key % n;
		cur = map_heads[b];
		prev = ENTRIES;
		steps = 0;
		if (op.func == FN_LOOKUP || op.func == FN_DELETE) begin
			while (cur < ENTRIES && steps < ENTRIES && map_keys[cur] != op.key) begin
				prev = cur;
				cur = map_links[cur];
				steps++;
			end
			if (steps >= ENTRIES) cur = ENTRIES;
		end
		case (op.func)
			FN_LOOKUP: if (cur < ENTRIES) begin
				r.found = 1'b1;
				r.read_value = map_vals[cur];
			end
			FN_INSERT: if (map_free_n == 0) begin
				r.status = 1'b1;
			end else begin
				map_free_n--;
				e = map_free[map_free_n];
				map_keys[e] = op.key;
				map_vals[e] = op.value;
				map_links[e] = map_heads[b];
				map_heads[b] = LW'(e);
			end
			FN_DELETE: if (cur < ENTRIES) begin
				r.found = 1'b1;
				if (prev < ENTRIES) map_links[prev] = map_links[cur];
				else map_heads[b] = map_links[cur];
				if (map_free_n < ENTRIES) begin
					map_free[map_free_n] = EW'(cur);
					map_free_n++;
				end
			end
			default: map_clear();
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		$display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, n_checked);
		errors++;
	endtask

	task automatic queue_op(logic [1:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		op_t op;
		op.func = f;
		op.key = k;
		op.value = v;
		pending_ops.push_back(op);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if (live_keys.size() > 0 && $urandom_range(0, 3) != 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		if ($urandom_range(0, 1)) return KEY_W'($urandom_range(0, 200));
		return KEY_W'($urandom);
	endfunction

	task automatic random_ops(int count, int clear_rate);
		logic [KEY_W-1:0] k;
		int sel;
		for (int i = 0; i < count; i++) begin
			k = pick_key();
			sel = $urandom_range(0, 99);
			if (sel < clear_rate) begin
				queue_op(FN_CLEAR, KEY_W'($urandom), $urandom);
				live_keys.delete();
			end else if (sel < 45) begin
				queue_op(FN_INSERT, k, $urandom);
				if (live_keys.size() < 64) live_keys.push_back(k);
			end else if (sel < 75) begin
				queue_op(FN_LOOKUP, k, $urandom);
			end else begin
				queue_op(FN_DELETE, k, $urandom);
			end
		end
	endtask

	task automatic drain();
		while (pending_ops.size() > 0 || expected_res.size() > 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic set_buckets(logic [6:0] n);
		@(negedge clk);
		cfg_data <= n;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		map_buckets = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver: hold the item until accepted
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready_q) begin
			if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				s_axis_tdata <= {7'b0, pending_ops[0].value, pending_ops[0].key,
					pending_ops[0].func};
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// acceptance at the rising edge feeds the map model
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tready_q <= 1'b0;
		end else begin
			s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				took = pending_ops.pop_front();
				expected_res.push_back(map_apply(took));
				n_sent++;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_res.size() == 0) begin
				report("unexpected result", m_axis_tdata[32:1], '0);
			end else begin
				want = expected_res.pop_front();
				if (m_axis_tdata[0] !== want.found)
					report("found", VAL_W'(m_axis_tdata[0]), VAL_W'(want.found));
				if (m_axis_tdata[32:1] !== want.read_value)
					report("read_value", m_axis_tdata[32:1], want.read_value);
				if (m_axis_tdata[33] !== want.status)
					report("status", VAL_W'(m_axis_tdata[33]), VAL_W'(want.status));
			end
			n_checked++;
		end
	end

	initial begin
		#40000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		send_idle = 0;
		recv_idle = 0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		map_buckets = 7'd64;
		map_clear();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every operation, chain head deletes and a delete of an absent key
		queue_op(FN_LOOKUP, 31'd5, 32'hFFFFFFFF);
		queue_op(FN_INSERT, 31'h7FFFFFFF, 32'hFFFFFFFF);
		queue_op(FN_INSERT, 31'd0, 32'd0);
		queue_op(FN_INSERT, 31'd64, 32'h12345678);
		queue_op(FN_INSERT, 31'd128, 32'hA5A5A5A5);
		queue_op(FN_INSERT, 31'd64, 32'h5A5A5A5A);
		queue_op(FN_LOOKUP, 31'd64, 32'd0);
		queue_op(FN_DELETE, 31'd64, 32'd0);
		queue_op(FN_LOOKUP, 31'd64, 32'd0);
		queue_op(FN_DELETE, 31'd128, 32'd0);
		queue_op(FN_LOOKUP, 31'd0, 32'd0);
		queue_op(FN_LOOKUP, 31'h7FFFFFFF, 32'd0);
		queue_op(FN_DELETE, 31'd77, 32'd0);
		queue_op(FN_CLEAR, 31'h7FFFFFFF, 32'hFFFFFFFF);
		queue_op(FN_LOOKUP, 31'd0, 32'd0);
		drain();

		// exhaust the pool, then refused inserts
		set_buckets(7'd1);
		for (int i = 0; i < ENTRIES + 2; i++) queue_op(FN_INSERT, KEY_W'(i % 8), $urandom);
		queue_op(FN_LOOKUP, 31'd3, 32'd0);
		queue_op(FN_DELETE, 31'd3, 32'd0);
		queue_op(FN_INSERT, 31'd99, 32'hCAFE0001);
		queue_op(FN_INSERT, 31'd98, 32'hCAFE0002);
		queue_op(FN_CLEAR, 31'd0, 32'd0);
		drain();

		// out-of-range counts and a change while entries are held
		set_buckets(7'd0);
		random_ops(60, 0);
		drain();
		set_buckets(7'd127);
		random_ops(60, 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 46; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 46; end
				default: begin send_idle = 11; recv_idle = 11; end
			endcase
			set_buckets(ph == 0 ? 7'd64 : ph == 4 ? 7'd1 : 7'($urandom_range(1, 64)));
			random_ops(180, 2);
			drain();
		end

		$display("Covered %0d items over bucket counts 0..127, pool exhaustion and clears.",
			n_sent);
		if (errors == 0 && expected_res.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> sim.f
src/chm_pkg.sv
src/chm_front.sv
src/chm_back.sv
src/chained_hash_map.sv
tb/chained_hash_map_test.sv
